/* hdl/slx_pkg.sv */
// shared types, constants and keyword table for the script lexer
package slx_pkg;

  localparam int unsigned MAX_SOURCE_BYTES = 65536;
  localparam int unsigned KEYWORD_CHARS = 8;
  localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);
  localparam int unsigned KW_BITS = KEYWORD_CHARS * 8;
  localparam int unsigned KI_W = $clog2(KEYWORD_CHARS);
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QP_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_KEYWORDS = 12;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] TAB_MAX = 16'hFFFF;

  localparam logic [4:0] K_LPAREN = 5'd0;
  localparam logic [4:0] K_RPAREN = 5'd1;
  localparam logic [4:0] K_EQUAL = 5'd2;
  localparam logic [4:0] K_DOUBLEEQUAL = 5'd3;
  localparam logic [4:0] K_PLUS = 5'd4;
  localparam logic [4:0] K_MINUS = 5'd5;
  localparam logic [4:0] K_STAR = 5'd6;
  localparam logic [4:0] K_SLASH = 5'd7;
  localparam logic [4:0] K_PERCENT = 5'd8;
  localparam logic [4:0] K_EXCLEQUAL = 5'd9;
  localparam logic [4:0] K_LESS = 5'd10;
  localparam logic [4:0] K_GREATER = 5'd11;
  localparam logic [4:0] K_COMMA = 5'd12;
  localparam logic [4:0] K_TAB = 5'd13;
  localparam logic [4:0] K_NEWLINE = 5'd14;
  localparam logic [4:0] K_STRING = 5'd15;
  localparam logic [4:0] K_NAME = 5'd16;
  localparam logic [4:0] K_NULL = 5'd17;
  localparam logic [4:0] K_INF = 5'd18;
  localparam logic [4:0] K_BOOL = 5'd19;
  localparam logic [4:0] K_AND = 5'd20;
  localparam logic [4:0] K_OR = 5'd21;
  localparam logic [4:0] K_IF = 5'd22;
  localparam logic [4:0] K_ELSE = 5'd23;
  localparam logic [4:0] K_ELIF = 5'd24;
  localparam logic [4:0] K_WHILE = 5'd25;
  localparam logic [4:0] K_FUNCTION = 5'd26;
  localparam logic [4:0] K_RETURN = 5'd27;
  localparam logic [4:0] K_INT = 5'd28;
  localparam logic [4:0] K_DECIMAL = 5'd29;
  localparam logic [4:0] K_ERROR = 5'd30;

  typedef enum logic [3:0] {
    M_IDLE, M_NAME, M_INT, M_POINT, M_FRAC, M_STRING, M_EQ, M_BANG, M_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    CL_NONE, CL_OTHER, CL_NL
  } class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_code;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] token_value;
    logic [3:0]  fraction_digits;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic        final_token;
  } out_item_t;

  // all tokens caused by one source byte
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] tok;
    logic [CNT_W-1:0]            cnt;
  } bundle_t;

  typedef struct packed {
    logic [KW_BITS-1:0] text;
    logic [3:0]         len;
    logic [4:0]         kind;
    logic               value;
  } kw_entry_t;

  // keyword text is left aligned, first character in the top byte
  function automatic kw_entry_t kw_entry(input int unsigned i);
    logic [63:0] txt;
    logic [3:0]  len;
    logic [4:0]  kind;
    logic        val;
    kw_entry_t   e;
    val = 1'b0;
    unique case (i)
      0:  begin txt = 64'("null");     len = 4'd4; kind = K_NULL;     end
      1:  begin txt = 64'("inf");      len = 4'd3; kind = K_INF;      end
      2:  begin txt = 64'("true");     len = 4'd4; kind = K_BOOL; val = 1'b1; end
      3:  begin txt = 64'("false");    len = 4'd5; kind = K_BOOL;     end
      4:  begin txt = 64'("and");      len = 4'd3; kind = K_AND;      end
      5:  begin txt = 64'("or");       len = 4'd2; kind = K_OR;       end
      6:  begin txt = 64'("if");       len = 4'd2; kind = K_IF;       end
      7:  begin txt = 64'("else");     len = 4'd4; kind = K_ELSE;     end
      8:  begin txt = 64'("elif");     len = 4'd4; kind = K_ELIF;     end
      9:  begin txt = 64'("while");    len = 4'd5; kind = K_WHILE;    end
      10: begin txt = 64'("function"); len = 4'd8; kind = K_FUNCTION; end
      default: begin txt = 64'("return"); len = 4'd6; kind = K_RETURN; end
    endcase
    e.text = KW_BITS'(txt) << (8 * (KEYWORD_CHARS - int'(len)));
    e.len = len;
    e.kind = kind;
    e.value = val;
    return e;
  endfunction

endpackage

/* hdl/slx_front.sv */
// front end: per-byte scanner that turns each source byte into a token bundle
module slx_front import slx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output bundle_t  bundle
);

  typedef struct packed {
    class_t      lec;
    logic        tp;
    logic [15:0] tr;
  } pend_t;

  mode_t              mode, mode_next;
  logic               tab_pending, tab_pending_next;
  logic [15:0]        tab_run, tab_run_next;
  class_t             last_class, last_class_next;
  logic [30:0]        acc, acc_next;
  logic [3:0]         frac, frac_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   start, start_next;
  logic [KW_BITS-1:0] kbuf, kbuf_next;

  function automatic out_item_t mk(input logic [4:0] k, input logic [30:0] v,
                                   input logic [3:0] f, input logic [15:0] o,
                                   input logic [15:0] l);
    out_item_t t;
    t.token_kind = k;
    t.token_value = v;
    t.fraction_digits = f;
    t.text_offset = o;
    t.text_length = l;
    t.final_token = 1'b0;
    return t;
  endfunction

  function automatic bundle_t push(input bundle_t b, input out_item_t t);
    bundle_t r;
    r = b;
    if (r.cnt < CNT_W'(MAX_RESULTS)) begin
      r.tok[r.cnt[IDX_W-1:0]] = t;
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [30:0] add_digit(input logic [30:0] a, input logic [7:0] c);
    logic [34:0] s;
    s = 35'({a, 3'b000}) + 35'({a, 1'b0}) + 35'(c - 8'h30);
    return (s > 35'(VALUE_MAX)) ? VALUE_MAX : s[30:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] low16(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  always_comb begin
    logic [7:0]        c;
    logic              was_err;
    logic              consumed;
    logic              hit;
    pend_t             p;
    bundle_t           b;
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  idx;
    logic [KW_BITS-1:0] mask;
    kw_entry_t         e;
    out_item_t         ft;
    logic [4:0]        fk;
    logic [30:0]       fv;
    logic [3:0]        ff;
    logic [15:0]       fo;
    logic [15:0]       fl;
    logic              do_emit;
    logic              do_raise;

    c = item.char_code;
    was_err = (mode == M_ERROR);
    consumed = 1'b0;
    b = '0;
    p.lec = last_class;
    p.tp = tab_pending;
    p.tr = tab_run;
    mode_next = mode;
    acc_next = acc;
    frac_next = frac;
    pos_next = pos;
    start_next = start;
    kbuf_next = kbuf;
    len = pos - start;
    idx = pos - start;
    mask = '0;
    hit = 1'b0;
    fk = K_NAME;
    fv = '0;
    ff = '0;
    fo = '0;
    fl = '0;
    do_emit = 1'b0;
    do_raise = 1'b0;
    e = '0;
    ft = '0;

    // keyword match on the name ending at this byte
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      e = kw_entry(i);
      mask = ~({KW_BITS{1'b1}} >> (8 * int'(e.len)));
      if (!hit && len == POS_W'(e.len) && ((kbuf ^ e.text) & mask) == '0) begin
        hit = 1'b1;
        fk = e.kind;
        fv = 31'(e.value);
      end
    end

    if (!was_err) begin
      if (32'(pos) >= 32'(MAX_SOURCE_BYTES)) begin
        do_raise = 1'b1;
      end else begin
        // token in progress
        unique case (mode)
          M_NAME: begin
            if (is_alpha(c) || is_digit(c)) begin
              consumed = 1'b1;
              if (32'(idx) < 32'(KEYWORD_CHARS))
                kbuf_next[KW_BITS-8-8*int'(idx[KI_W-1:0]) +: 8] = c;
            end else begin
              mode_next = M_IDLE;
              do_emit = 1'b1;
              if (!hit) begin
                fk = K_NAME;
                fv = '0;
                fo = low16(start);
                fl = sat16(len);
              end
            end
          end
          M_INT: begin
            if (is_digit(c)) begin
              consumed = 1'b1;
              acc_next = add_digit(acc, c);
            end else if (c == ".") begin
              consumed = 1'b1;
              mode_next = M_POINT;
            end else begin
              do_emit = 1'b1;
              fk = K_INT;
              fv = acc;
              mode_next = M_IDLE;
            end
          end
          M_POINT: begin
            consumed = 1'b1;
            if (is_digit(c)) begin
              acc_next = add_digit(acc, c);
              frac_next = 4'd1;
              mode_next = M_FRAC;
            end else begin
              do_raise = 1'b1;
            end
          end
          M_FRAC: begin
            if (is_digit(c)) begin
              consumed = 1'b1;
              acc_next = add_digit(acc, c);
              if (frac != 4'd15) frac_next = frac + 4'd1;
            end else begin
              do_emit = 1'b1;
              fk = K_DECIMAL;
              fv = acc;
              ff = frac;
              mode_next = M_IDLE;
            end
          end
          M_STRING: begin
            consumed = 1'b1;
            if (c == "\"") begin
              do_emit = 1'b1;
              fk = K_STRING;
              fv = '0;
              fo = low16(start);
              fl = sat16(len);
              mode_next = M_IDLE;
            end else if (c == 8'h0A) begin
              do_raise = 1'b1;
            end
          end
          M_EQ: begin
            mode_next = M_IDLE;
            do_emit = 1'b1;
            fv = '0;
            if (c == "=") begin
              consumed = 1'b1;
              fk = K_DOUBLEEQUAL;
            end else begin
              fk = K_EQUAL;
            end
          end
          M_BANG: begin
            consumed = 1'b1;
            if (c == "=") begin
              do_emit = 1'b1;
              fk = K_EXCLEQUAL;
              fv = '0;
              mode_next = M_IDLE;
            end else begin
              do_raise = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (do_raise) begin
        do_emit = 1'b1;
        fk = K_ERROR;
        fv = '0;
        ff = '0;
        fo = '0;
        fl = '0;
        mode_next = M_ERROR;
      end

      if (do_emit) begin
        if (p.lec == CL_NL) begin
          b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
          p.lec = CL_OTHER;
        end
        if (p.tp) begin
          b = push(b, mk(K_TAB, 31'(p.tr), '0, '0, '0));
          p.tp = 1'b0;
          p.tr = '0;
        end
        b = push(b, mk(fk, fv, ff, fo, fl));
        p.lec = CL_OTHER;
      end

      // byte not taken by a token in progress: whitespace, tab, newline or the start of a token
      if (!consumed && mode_next == M_IDLE && !do_raise) begin
        do_emit = 1'b0;
        do_raise = 1'b0;
        fk = K_ERROR;
        unique case (c)
          8'h20, 8'h0D, 8'h0B, 8'h0C: ;
          "(": begin do_emit = 1'b1; fk = K_LPAREN; end
          ")": begin do_emit = 1'b1; fk = K_RPAREN; end
          "+": begin do_emit = 1'b1; fk = K_PLUS; end
          "-": begin do_emit = 1'b1; fk = K_MINUS; end
          "*": begin do_emit = 1'b1; fk = K_STAR; end
          "/": begin do_emit = 1'b1; fk = K_SLASH; end
          "%": begin do_emit = 1'b1; fk = K_PERCENT; end
          "<": begin do_emit = 1'b1; fk = K_LESS; end
          ">": begin do_emit = 1'b1; fk = K_GREATER; end
          ",": begin do_emit = 1'b1; fk = K_COMMA; end
          "=": mode_next = M_EQ;
          "!": mode_next = M_BANG;
          8'h09: begin
            if (p.tp) begin
              if (p.tr != TAB_MAX) p.tr = p.tr + 16'd1;
            end else begin
              p.tp = 1'b1;
              p.tr = 16'd1;
            end
          end
          8'h0A: begin
            // newline after tabs drops the tab run
            if (p.tp) begin
              p.tp = 1'b0;
              p.tr = '0;
            end else if (p.lec == CL_OTHER) begin
              p.lec = CL_NL;
            end
          end
          "\"": begin
            mode_next = M_STRING;
            start_next = pos + 1'b1;
          end
          default: begin
            if (is_alpha(c)) begin
              mode_next = M_NAME;
              start_next = pos;
              kbuf_next[KW_BITS-1 -: 8] = c;
            end else if (is_digit(c)) begin
              mode_next = M_INT;
              acc_next = add_digit('0, c);
              frac_next = '0;
            end else begin
              do_emit = 1'b1;
              mode_next = M_ERROR;
            end
          end
        endcase
        // these open a token and so release what is pending
        if (do_emit || mode_next != M_IDLE) begin
          if (p.lec == CL_NL) begin
            b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
            p.lec = CL_OTHER;
          end
          if (p.tp) begin
            b = push(b, mk(K_TAB, 31'(p.tr), '0, '0, '0));
            p.tp = 1'b0;
            p.tr = '0;
          end
        end
        if (do_emit) begin
          b = push(b, mk(fk, '0, '0, '0, '0));
          p.lec = CL_OTHER;
        end
      end

      if (32'(pos) < 32'(MAX_SOURCE_BYTES)) pos_next = pos + 1'b1;
    end

    if (item.end_of_code) begin
      if (was_err) begin
        b = push(b, mk(K_ERROR, '0, '0, '0, '0));
      end else if (mode_next != M_ERROR) begin
        do_emit = 1'b1;
        fv = '0;
        ff = '0;
        fo = '0;
        fl = '0;
        len = pos_next - start_next;
        unique case (mode_next)
          M_NAME: begin
            // name text is complete in the buffer by now
            hit = 1'b0;
            fk = K_NAME;
            for (int i = 0; i < NUM_KEYWORDS; i++) begin
              e = kw_entry(i);
              mask = ~({KW_BITS{1'b1}} >> (8 * int'(e.len)));
              if (!hit && len == POS_W'(e.len) && ((kbuf_next ^ e.text) & mask) == '0) begin
                hit = 1'b1;
                fk = e.kind;
                fv = 31'(e.value);
              end
            end
            if (!hit) begin
              fo = low16(start_next);
              fl = sat16(len);
            end
          end
          M_INT: begin fk = K_INT; fv = acc_next; end
          M_FRAC: begin fk = K_DECIMAL; fv = acc_next; ff = frac_next; end
          M_EQ: fk = K_EQUAL;
          M_POINT, M_STRING, M_BANG: fk = K_ERROR;
          default: do_emit = 1'b0;
        endcase
        if (do_emit) begin
          if (p.lec == CL_NL) begin
            b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
            p.lec = CL_OTHER;
          end
          if (p.tp) begin
            b = push(b, mk(K_TAB, 31'(p.tr), '0, '0, '0));
            p.tp = 1'b0;
            p.tr = '0;
          end
          b = push(b, mk(fk, fv, ff, fo, fl));
          p.lec = CL_OTHER;
        end
        if (!(do_emit && fk == K_ERROR)) begin
          if (p.tp) begin
            if (p.lec == CL_NL)
              b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
            b = push(b, mk(K_TAB, 31'(p.tr), '0, '0, '0));
            b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
          end else if (p.lec != CL_NONE) begin
            b = push(b, mk(K_NEWLINE, '0, '0, '0, '0));
          end
        end
      end
      if (b.cnt != '0) begin
        ft = b.tok[IDX_W'(b.cnt - 1'b1)];
        ft.final_token = 1'b1;
        b.tok[IDX_W'(b.cnt - 1'b1)] = ft;
      end
      // fresh start for the next source
      mode_next = M_IDLE;
      p.lec = CL_NONE;
      p.tp = 1'b0;
      p.tr = '0;
      acc_next = '0;
      frac_next = '0;
      pos_next = '0;
      start_next = '0;
    end

    tab_pending_next = p.tp;
    tab_run_next = p.tr;
    last_class_next = p.lec;
    bundle = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      tab_pending <= 1'b0;
      tab_run <= '0;
      last_class <= CL_NONE;
      acc <= '0;
      frac <= '0;
      pos <= '0;
      start <= '0;
    end else if (take) begin
      mode <= mode_next;
      tab_pending <= tab_pending_next;
      tab_run <= tab_run_next;
      last_class <= last_class_next;
      acc <= acc_next;
      frac <= frac_next;
      pos <= pos_next;
      start <= start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) kbuf <= kbuf_next;
  end

endmodule

/* hdl/slx_queue.sv */
// short queue of token bundles between scanner and output side
module slx_queue import slx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  input  logic    pop,
  output bundle_t head,
  output logic    nonempty,
  output logic    full
);

  bundle_t          slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wptr, rptr;
  logic [QC_W-1:0]  count;

  assign head = slots[rptr];
  assign nonempty = (count != '0);
  assign full = (count == QC_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

endmodule

/* hdl/slx_back.sv */
// back end: hands out the tokens of each bundle one per cycle while the output is not stalled
module slx_back import slx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   head,
  input  logic      nonempty,
  output logic      pop,
  output logic      valid,
  input  logic      stall,
  output out_item_t data
);

  bundle_t          cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             last_tok;
  logic             done;

  assign valid = cur_valid;
  assign data = cur.tok[idx];
  assign last_tok = (CNT_W'(idx) + 1'b1 == cur.cnt);
  assign done = cur_valid && !stall && last_tok;
  assign pop = nonempty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (cur_valid && !stall) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

endmodule

/* hdl/script_lexer_stream.sv */
// top level of the streaming script tokenizer
// One source byte is taken per cycle whenever the token queue has room; a
// byte causes zero to four tokens, which leave one per cycle unless stalled.
// The output side therefore sets the sustained rate: bytes that end tokens
// (up to four tokens on the end byte) occupy the output longer, and the
// four-entry bundle queue lets the scanner run ahead meanwhile. Tokens pass
// through the bundle queue and the bundle register of the back end.
module script_lexer_stream import slx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  bundle_t bundle, head;
  logic    take, full, nonempty, pop;

  assign in_stall = full;
  assign take = in_valid && !full;

  slx_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (in_data),
    .bundle (bundle)
  );

  // bytes with no token never enter the queue
  slx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take && bundle.cnt != '0),
    .wdata    (bundle),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .full     (full)
  );

  slx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .valid    (out_valid),
    .stall    (out_stall),
    .data     (out_data)
  );

endmodule

/* tb/tb_script_lexer_stream.sv */
// self-checking testbench for the streaming script tokenizer
`timescale 1ns / 100ps

module tb_script_lexer_stream;
  import slx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  script_lexer_stream u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // tokenizer state mirror
  mode_t       scan_mode;
  logic        tab_pending;
  logic [15:0] tab_run;
  class_t      last_class;
  logic [30:0] num_acc;
  logic [3:0]  frac_cnt;
  int unsigned src_pos;
  int unsigned tok_start;
  logic [7:0]  name_buf [KEYWORD_CHARS];

  out_item_t token_queue[$];
  out_item_t step_toks[$];
  int unsigned errors;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void clear_lexer();
    scan_mode = M_IDLE;
    tab_pending = 1'b0;
    tab_run = '0;
    last_class = CL_NONE;
    num_acc = '0;
    frac_cnt = '0;
    src_pos = 0;
    tok_start = 0;
    for (int i = 0; i < KEYWORD_CHARS; i++) name_buf[i] = 8'h00;
  endfunction

  function automatic void push_tok(input logic [4:0] kind, input logic [30:0] val,
                                   input int unsigned frac, input int unsigned off,
                                   input int unsigned len);
    out_item_t t;
    if (step_toks.size() >= MAX_RESULTS) return;
    t.token_kind = kind;
    t.token_value = val;
    t.fraction_digits = frac > 15 ? 4'd15 : 4'(frac);
    t.text_offset = 16'(off);
    t.text_length = len > 65535 ? 16'hFFFF : 16'(len);
    t.final_token = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void flush_held();
    if (last_class == CL_NL) begin
      push_tok(K_NEWLINE, 0, 0, 0, 0);
      last_class = CL_OTHER;
    end
    if (tab_pending) begin
      push_tok(K_TAB, 31'(tab_run), 0, 0, 0);
      tab_pending = 1'b0;
      tab_run = '0;
      last_class = CL_OTHER;
    end
  endfunction

  function automatic void emit_tok(input logic [4:0] kind, input logic [30:0] val,
                                   input int unsigned frac, input int unsigned off,
                                   input int unsigned len);
    flush_held();
    push_tok(kind, val, frac, off, len);
    last_class = CL_OTHER;
  endfunction

  function automatic void lex_error();
    emit_tok(K_ERROR, 0, 0, 0, 0);
    scan_mode = M_ERROR;
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    int unsigned d;
    d = c - "0";
    if (num_acc > (VALUE_MAX - d) / 10) num_acc = VALUE_MAX;
    else num_acc = num_acc * 10 + d;
  endfunction

  function automatic void end_name();
    int unsigned len;
    kw_entry_t e;
    bit hit;
    len = src_pos - tok_start;
    scan_mode = M_IDLE;
    if (len <= KEYWORD_CHARS) begin
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        e = kw_entry(i);
        if (e.len == len) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++)
            if (name_buf[j] != e.text[KW_BITS-1-8*j -: 8]) hit = 1'b0;
          if (hit) begin
            emit_tok(e.kind, 31'(e.value), 0, 0, 0);
            return;
          end
        end
      end
    end
    emit_tok(K_NAME, 0, 0, tok_start, len);
  endfunction

  function automatic void idle_char(input logic [7:0] c);
    case (c)
      8'h20, 8'h0D, 8'h0B, 8'h0C: ;
      "(": emit_tok(K_LPAREN, 0, 0, 0, 0);
      ")": emit_tok(K_RPAREN, 0, 0, 0, 0);
      "+": emit_tok(K_PLUS, 0, 0, 0, 0);
      "-": emit_tok(K_MINUS, 0, 0, 0, 0);
      "*": emit_tok(K_STAR, 0, 0, 0, 0);
      "/": emit_tok(K_SLASH, 0, 0, 0, 0);
      "%": emit_tok(K_PERCENT, 0, 0, 0, 0);
      "<": emit_tok(K_LESS, 0, 0, 0, 0);
      ">": emit_tok(K_GREATER, 0, 0, 0, 0);
      ",": emit_tok(K_COMMA, 0, 0, 0, 0);
      "=": begin flush_held(); scan_mode = M_EQ; end
      "!": begin flush_held(); scan_mode = M_BANG; end
      8'h09: begin
        if (tab_pending) begin
          if (tab_run != TAB_MAX) tab_run++;
        end else begin
          tab_pending = 1'b1;
          tab_run = 16'd1;
        end
      end
      8'h0A: begin
        if (tab_pending) begin
          tab_pending = 1'b0;
          tab_run = '0;
        end else if (last_class == CL_OTHER) begin
          last_class = CL_NL;
        end
      end
      8'h22: begin
        flush_held();
        scan_mode = M_STRING;
        tok_start = src_pos + 1;
      end
      default: begin
        if (is_alp(c)) begin
          flush_held();
          scan_mode = M_NAME;
          tok_start = src_pos;
          name_buf[0] = c;
        end else if (is_dig(c)) begin
          flush_held();
          scan_mode = M_INT;
          num_acc = '0;
          frac_cnt = '0;
          add_digit(c);
        end else begin
          lex_error();
        end
      end
    endcase
  endfunction

  // returns 1 when the byte was taken by the token in progress
  function automatic bit extend_token(input logic [7:0] c);
    int unsigned idx;
    case (scan_mode)
      M_NAME: begin
        if (is_alp(c) || is_dig(c)) begin
          idx = src_pos - tok_start;
          if (idx < KEYWORD_CHARS) name_buf[idx] = c;
          return 1'b1;
        end
        end_name();
        return 1'b0;
      end
      M_INT: begin
        if (is_dig(c)) begin add_digit(c); return 1'b1; end
        if (c == ".") begin scan_mode = M_POINT; return 1'b1; end
        emit_tok(K_INT, num_acc, 0, 0, 0);
        scan_mode = M_IDLE;
        return 1'b0;
      end
      M_POINT: begin
        if (is_dig(c)) begin
          add_digit(c);
          frac_cnt = 4'd1;
          scan_mode = M_FRAC;
        end else begin
          lex_error();
        end
        return 1'b1;
      end
      M_FRAC: begin
        if (is_dig(c)) begin
          add_digit(c);
          if (frac_cnt < 4'd15) frac_cnt++;
          return 1'b1;
        end
        emit_tok(K_DECIMAL, num_acc, frac_cnt, 0, 0);
        scan_mode = M_IDLE;
        return 1'b0;
      end
      M_STRING: begin
        if (c == 8'h22) begin
          emit_tok(K_STRING, 0, 0, tok_start, src_pos - tok_start);
          scan_mode = M_IDLE;
        end else if (c == 8'h0A) begin
          lex_error();
        end
        return 1'b1;
      end
      M_EQ: begin
        scan_mode = M_IDLE;
        if (c == "=") begin emit_tok(K_DOUBLEEQUAL, 0, 0, 0, 0); return 1'b1; end
        emit_tok(K_EQUAL, 0, 0, 0, 0);
        return 1'b0;
      end
      M_BANG: begin
        if (c == "=") begin
          emit_tok(K_EXCLEQUAL, 0, 0, 0, 0);
          scan_mode = M_IDLE;
        end else begin
          lex_error();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void close_open_token();
    case (scan_mode)
      M_NAME: end_name();
      M_INT: begin emit_tok(K_INT, num_acc, 0, 0, 0); scan_mode = M_IDLE; end
      M_FRAC: begin emit_tok(K_DECIMAL, num_acc, frac_cnt, 0, 0); scan_mode = M_IDLE; end
      M_EQ: begin emit_tok(K_EQUAL, 0, 0, 0, 0); scan_mode = M_IDLE; end
      M_POINT, M_STRING, M_BANG: lex_error();
      default: ;
    endcase
  endfunction

  // tokens caused by one source byte, appended to the expected queue
  function automatic void lex_byte(input in_item_t it);
    bit was_err;
    was_err = (scan_mode == M_ERROR);
    step_toks.delete();
    if (!was_err) begin
      if (src_pos >= MAX_SOURCE_BYTES) lex_error();
      else if (!extend_token(it.char_code) && scan_mode == M_IDLE) idle_char(it.char_code);
      if (src_pos < MAX_SOURCE_BYTES) src_pos++;
    end
    if (it.end_of_code) begin
      if (was_err) begin
        push_tok(K_ERROR, 0, 0, 0, 0);
      end else if (scan_mode != M_ERROR) begin
        close_open_token();
        if (scan_mode != M_ERROR) begin
          if (tab_pending) begin
            flush_held();
            push_tok(K_NEWLINE, 0, 0, 0, 0);
          end else if (last_class != CL_NONE) begin
            push_tok(K_NEWLINE, 0, 0, 0, 0);
          end
        end
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].final_token = 1'b1;
      clear_lexer();
    end
    foreach (step_toks[i]) token_queue.insert(token_queue.size(), step_toks[i]);
  endfunction

  // receiver: stall pattern and checking
  always @(posedge clk) begin
    out_item_t exp_tok;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d", out_data.token_kind));
        end else begin
          exp_tok = token_queue.pop_front();
          if (out_data.token_kind !== exp_tok.token_kind)
            report_mismatch($sformatf("token_kind %0d, want %0d",
                                      out_data.token_kind, exp_tok.token_kind));
          if (out_data.token_value !== exp_tok.token_value)
            report_mismatch($sformatf("token_value %0d, want %0d",
                                      out_data.token_value, exp_tok.token_value));
          if (out_data.fraction_digits !== exp_tok.fraction_digits)
            report_mismatch($sformatf("fraction_digits %0d, want %0d",
                                      out_data.fraction_digits, exp_tok.fraction_digits));
          if (out_data.text_offset !== exp_tok.text_offset)
            report_mismatch($sformatf("text_offset %0d, want %0d",
                                      out_data.text_offset, exp_tok.text_offset));
          if (out_data.text_length !== exp_tok.text_length)
            report_mismatch($sformatf("text_length %0d, want %0d",
                                      out_data.text_length, exp_tok.text_length));
          if (out_data.final_token !== exp_tok.final_token)
            report_mismatch($sformatf("final_token %0d, want %0d",
                                      out_data.final_token, exp_tok.final_token));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one byte, predicting its tokens when it is taken
  task automatic send_byte(input logic [7:0] c, input bit last);
    in_item_t it;
    it.char_code = c;
    it.end_of_code = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    string pool;
    pool = "()+-*/%<>,=!\"._ \t\n0123456789abcdefghijklmnopqrstuvwxyzAZ";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  // well-formed line fragments with random content
  function automatic string pick_phrase();
    string words[14];
    string s;
    words = '{"function", "return", "while", "elif", "null", "inf", "true",
              "false", "and", "or", "if", "else", "abcdefghij", "x1_y"};
    case ($urandom_range(11))
      0, 1: s = words[$urandom_range(13)];
      2: s = $sformatf("%0d", $urandom);
      3: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99999));
      4: s = "\"str ing\"";
      5: s = "==";
      6: s = "!=";
      7: s = "\t\t";
      8: s = "\n";
      9: s = " = ";
      10: s = "(a,b)";
      default: s = "+-*/%<>";
    endcase
    return {s, " "};
  endfunction

  task automatic send_random_source(input int unsigned n);
    string s;
    s = "";
    while (s.len() < n) begin
      if ($urandom_range(9) == 0) s = {s, string'(pick_char())};
      else s = {s, pick_phrase()};
    end
    if ($urandom_range(3) == 0) s = {s, string'(pick_char())};
    send_text(s);
  endtask

  typedef struct {
    logic [7:0] c;
    bit         last;
    bit         check;
    out_item_t  want;
  } stim_row_t;

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    stim_row_t rows[$];
    out_item_t blank;
    string     dir_text;
    blank = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_lexer();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // lone byte 0xFF on the end byte: one final error token
    rows.insert(rows.size(), '{8'hFF, 1'b1, 1'b1, '{K_ERROR, 31'd0, 4'd0, 16'd0, 16'd0, 1'b1}});
    // lone blank end byte: nothing emitted
    rows.insert(rows.size(), '{8'h20, 1'b1, 1'b0, blank});
    // saturating integer, double equal, bang equal, newline collapse, tabs
    dir_text = "99999999999==";
    for (int i = 0; i < dir_text.len(); i++)
      rows.insert(rows.size(), '{dir_text[i], 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{"!", 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{"=", 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{8'h0A, 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{8'h0A, 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{8'h09, 1'b0, 1'b0, blank});
    rows.insert(rows.size(), '{8'h09, 1'b1, 1'b0, blank});
    foreach (rows[i]) begin
      if (rows[i].check) begin
        send_byte(rows[i].c, rows[i].last);
        if (token_queue.size() != 1 || token_queue[0] !== rows[i].want)
          report_mismatch("directed row prediction");
      end else begin
        send_byte(rows[i].c, rows[i].last);
      end
    end
    send_text("function return while elif null inf true false and or if else");
    send_text("\t\t\nx_9 \"s\"1.25 =(");
    send_text("a.b !x \"q\nzz (");
    send_text("7.");
    send_text("9.1234567890123456789+");
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int k = 0; k < 2; k++) send_random_source($urandom_range(4, 16));
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* script_lexer_stream.f */
hdl/slx_pkg.sv
hdl/slx_front.sv
hdl/slx_queue.sv
hdl/slx_back.sv
hdl/script_lexer_stream.sv
tb/tb_script_lexer_stream.sv
